[hdl/fbs_pkg.sv]
// ----------------------------------------------------------------------------
// fbs_pkg: shared types and constants of the face box filter and squarer
// Field widths, register codes, reset values and inter-module structs.
// ----------------------------------------------------------------------------
package fbs_pkg;

  localparam int COORD_BITS = 12;

  localparam int SCORE_W    = 16;
  localparam int NORM_W     = 18;
  localparam int COUNT_W    = 8;
  localparam int DIM_CFG_W  = 13;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 16;

  // clamped frame dimension, up to 2^COORD_BITS
  localparam int DIM_W  = COORD_BITS + 1;
  localparam int CMP_W  = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
  // pixel coordinate, signed, covers +-2 frames
  localparam int PIX_W  = COORD_BITS + 2;
  // box size and centre arithmetic, signed
  localparam int SIZE_W = PIX_W + 2;
  localparam int PROD_W = NORM_W + DIM_W + 1;
  localparam int D_W    = SIZE_W + SCALE_W + 1;

  localparam int MIN_DIM = 16;
  localparam int MAX_DIM = 1 << COORD_BITS;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [SCORE_W-1:0]   RST_SCORE_THR  = 16'd32768;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_W    = 13'd640;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_H    = 13'd480;
  localparam logic [COUNT_W-1:0]   RST_MAX_FACES  = 8'd16;
  localparam logic [DIM_CFG_W-1:0] RST_MIN_SIDE   = 13'd16;
  localparam logic [SCALE_W-1:0]   RST_SIDE_SCALE = 16'd52429;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THR  = 3'd0,
    REG_FRAME_W    = 3'd1,
    REG_FRAME_H    = 3'd2,
    REG_MAX_FACES  = 3'd3,
    REG_MIN_SIDE   = 3'd4,
    REG_SIDE_SCALE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   min_dim;
    logic [DIM_W-1:0]   min_side;
    logic [SCALE_W-1:0] side_scale;
  } geom_cfg_t;

  typedef struct packed {
    logic               keep;
    logic [COUNT_W-1:0] faces;
    logic               frame_end;
  } meta_t;

  typedef struct packed {
    meta_t                    meta;
    logic signed [NORM_W-1:0] left;
    logic signed [NORM_W-1:0] top;
    logic signed [NORM_W-1:0] right;
    logic signed [NORM_W-1:0] bottom;
  } job_t;

endpackage

[hdl/fbs_box_if.sv]
// ----------------------------------------------------------------------------
// fbs_box_if: detector box request channel
// Valid/ready handshake carrying one score and four normalized corners.
// ----------------------------------------------------------------------------
interface fbs_box_if;
  logic                             valid;
  logic                             ready;
  logic [fbs_pkg::SCORE_W-1:0]      box_score;
  logic signed [fbs_pkg::NORM_W-1:0] norm_left;
  logic signed [fbs_pkg::NORM_W-1:0] norm_top;
  logic signed [fbs_pkg::NORM_W-1:0] norm_right;
  logic signed [fbs_pkg::NORM_W-1:0] norm_bottom;
  logic                             frame_end;

  modport source (
    output valid, box_score, norm_left, norm_top, norm_right, norm_bottom, frame_end,
    input  ready
  );
  modport sink (
    input  valid, box_score, norm_left, norm_top, norm_right, norm_bottom, frame_end,
    output ready
  );
endinterface

[hdl/fbs_sq_if.sv]
// ----------------------------------------------------------------------------
// fbs_sq_if: square crop result channel
// Valid/ready handshake carrying the kept flag, square edges and face count.
// ----------------------------------------------------------------------------
interface fbs_sq_if;
  logic                           valid;
  logic                           ready;
  logic                           kept;
  logic [fbs_pkg::COORD_BITS-1:0] square_left;
  logic [fbs_pkg::COORD_BITS-1:0] square_top;
  logic [fbs_pkg::COORD_BITS-1:0] square_right;
  logic [fbs_pkg::COORD_BITS-1:0] square_bottom;
  logic [fbs_pkg::COUNT_W-1:0]    faces_so_far;
  logic                           last_of_frame;

  modport source (
    output valid, kept, square_left, square_top, square_right, square_bottom,
           faces_so_far, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, kept, square_left, square_top, square_right, square_bottom,
           faces_so_far, last_of_frame,
    output ready
  );
endinterface

[hdl/fbs_front.sv]
// ----------------------------------------------------------------------------
// fbs_front: request intake, keep decision and configuration registers
// Decides keep per box, tracks the per-frame face count, hands jobs onward.
// ----------------------------------------------------------------------------
module fbs_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fbs_box_if.sink                          box_i,
  input  logic                             cfg_we_i,
  input  logic [fbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output fbs_pkg::job_t                    job_o,
  output logic                             job_vld_o,
  input  logic                             job_rdy_i,
  output fbs_pkg::geom_cfg_t               geom_o
);

  localparam int CmpW    = fbs_pkg::CMP_W;
  localparam int DimW    = fbs_pkg::DIM_W;
  localparam int DimCfgW = fbs_pkg::DIM_CFG_W;
  localparam int CountW  = fbs_pkg::COUNT_W;

  logic [fbs_pkg::SCORE_W-1:0] score_thr_q;
  logic [DimCfgW-1:0]          frame_w_q, frame_h_q, min_side_q;
  logic [CountW-1:0]           max_faces_q;
  logic [fbs_pkg::SCALE_W-1:0] side_scale_q;
  logic [CountW-1:0]           kept_count_q, kept_count_d;

  logic              accept;
  logic              keep;
  logic [CountW-1:0] faces;
  logic [DimW-1:0]   dim_w, dim_h, dim_min;
  logic [CmpW-1:0]   side_ext;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimCfgW-1:0] v);
    logic [CmpW-1:0] x;
    x = CmpW'(v);
    if (x < CmpW'(fbs_pkg::MIN_DIM)) x = CmpW'(fbs_pkg::MIN_DIM);
    if (x > CmpW'(fbs_pkg::MAX_DIM)) x = CmpW'(fbs_pkg::MAX_DIM);
    return DimW'(x);
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q  <= fbs_pkg::RST_SCORE_THR;
      frame_w_q    <= fbs_pkg::RST_FRAME_W;
      frame_h_q    <= fbs_pkg::RST_FRAME_H;
      max_faces_q  <= fbs_pkg::RST_MAX_FACES;
      min_side_q   <= fbs_pkg::RST_MIN_SIDE;
      side_scale_q <= fbs_pkg::RST_SIDE_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbs_pkg::REG_SCORE_THR:  score_thr_q  <= cfg_data_i[fbs_pkg::SCORE_W-1:0];
        fbs_pkg::REG_FRAME_W:    frame_w_q    <= cfg_data_i[DimCfgW-1:0];
        fbs_pkg::REG_FRAME_H:    frame_h_q    <= cfg_data_i[DimCfgW-1:0];
        fbs_pkg::REG_MAX_FACES:  max_faces_q  <= cfg_data_i[CountW-1:0];
        fbs_pkg::REG_MIN_SIDE:   min_side_q   <= cfg_data_i[DimCfgW-1:0];
        fbs_pkg::REG_SIDE_SCALE: side_scale_q <= cfg_data_i[fbs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // derived geometry; the user keeps it static while items are in flight, the block does not enforce it
  always_comb begin
    dim_w    = clamp_dim(frame_w_q);
    dim_h    = clamp_dim(frame_h_q);
    dim_min  = (dim_w < dim_h) ? dim_w : dim_h;
    side_ext = CmpW'(min_side_q);
    geom_o.width      = dim_w;
    geom_o.height     = dim_h;
    geom_o.min_dim    = dim_min;
    geom_o.min_side   = (side_ext > CmpW'(dim_min)) ? dim_min : DimW'(side_ext);
    geom_o.side_scale = side_scale_q;
  end

  assign accept      = box_i.valid && job_rdy_i;
  assign box_i.ready = job_rdy_i;
  assign job_vld_o   = box_i.valid;

  always_comb begin
    keep  = (box_i.box_score > score_thr_q) && (kept_count_q < max_faces_q);
    faces = keep ? kept_count_q + CountW'(1) : kept_count_q;
    kept_count_d = kept_count_q;
    if (accept) kept_count_d = box_i.frame_end ? '0 : faces;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count_q <= '0;
    end else begin
      kept_count_q <= kept_count_d;
    end
  end

  always_comb begin
    job_o.meta.keep      = keep;
    job_o.meta.faces     = faces;
    job_o.meta.frame_end = box_i.frame_end;
    job_o.left           = box_i.norm_left;
    job_o.top            = box_i.norm_top;
    job_o.right          = box_i.norm_right;
    job_o.bottom         = box_i.norm_bottom;
  end

endmodule

[hdl/fbs_queue.sv]
// ----------------------------------------------------------------------------
// fbs_queue: short job queue between front and back
// Register FIFO; lets the intake keep taking requests while the back stalls.
// ----------------------------------------------------------------------------
module fbs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbs_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output fbs_pkg::job_t pop_data_o,
  output logic          empty_o
);

  localparam int Depth = fbs_pkg::QDEPTH;
  localparam int PtrW  = fbs_pkg::QPTR_W;

  fbs_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (PtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[hdl/fbs_back.sv]
// ----------------------------------------------------------------------------
// fbs_back: square geometry pipeline and output register
// Five stages of scaling, sizing and clamping, then the result register.
// ----------------------------------------------------------------------------
module fbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbs_pkg::job_t      job_i,
  input  logic               job_vld_i,
  output logic               pop_o,
  input  fbs_pkg::geom_cfg_t geom_i,
  fbs_sq_if.source           sq_o
);

  localparam int CoordW = fbs_pkg::COORD_BITS;
  localparam int NormW  = fbs_pkg::NORM_W;
  localparam int DimW   = fbs_pkg::DIM_W;
  localparam int PixW   = fbs_pkg::PIX_W;
  localparam int SizeW  = fbs_pkg::SIZE_W;
  localparam int ProdW  = fbs_pkg::PROD_W;
  localparam int DW     = fbs_pkg::D_W;
  localparam int FracB  = fbs_pkg::FRAC_BITS;

  localparam logic signed [SizeW-1:0] One  = SizeW'(1);
  localparam logic signed [SizeW-1:0] Top  = SizeW'((1 << CoordW) - 1);
  localparam logic signed [ProdW-1:0] Bias = ProdW'((1 << FracB) - 1);

  // norm * size / 2^16, truncated toward zero
  function automatic logic signed [PixW-1:0] to_pixel(input logic signed [NormW-1:0] n,
                                                      input logic [DimW-1:0] size);
    logic signed [ProdW-1:0] p;
    p = n * $signed({1'b0, size});
    if (p < 0) p = p + Bias;
    return p[FracB +: PixW];
  endfunction

  function automatic logic [CoordW-1:0] edge_sat(input logic signed [SizeW-1:0] e);
    logic [CoordW-1:0] r;
    if (e < 0)        r = '0;
    else if (e > Top) r = '1;
    else              r = e[CoordW-1:0];
    return r;
  endfunction

  logic adv;
  logic out_vld_q;

  assign adv   = !out_vld_q || sq_o.ready;
  assign pop_o = adv && job_vld_i;

  // stage valids
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  fbs_pkg::meta_t s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q, s5_meta_q;

  // stage 1: pixels
  logic signed [PixW-1:0] s1_x1_q, s1_y1_q, s1_x2_q, s1_y2_q;
  // stage 2: size and centre
  logic signed [SizeW-1:0] s2_m_q;
  logic signed [PixW-1:0]  s2_cx_q, s2_cy_q;
  // stage 3: scaled side
  logic signed [DW-1:0]    s3_d_q;
  logic signed [PixW-1:0]  s3_cx_q, s3_cy_q;
  // stage 4: half side
  logic [CoordW-1:0]       s4_d2_q;
  logic signed [PixW-1:0]  s4_cx_q, s4_cy_q;
  // stage 5: clamped centre
  logic [CoordW-1:0]       s5_d2_q;
  logic signed [SizeW-1:0] s5_cx_q, s5_cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= job_vld_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  // stage 2 logic
  logic signed [SizeW-1:0] w2, h2, x1e, x2e, y1e, y2e;
  logic signed [PixW:0]    sx, sy, sxa, sya;
  always_comb begin
    x1e = SizeW'(s1_x1_q);
    x2e = SizeW'(s1_x2_q);
    y1e = SizeW'(s1_y1_q);
    y2e = SizeW'(s1_y2_q);
    w2  = x2e - x1e + One;
    h2  = y2e - y1e + One;
    sx  = (PixW+1)'(s1_x1_q) + (PixW+1)'(s1_x2_q);
    sy  = (PixW+1)'(s1_y1_q) + (PixW+1)'(s1_y2_q);
    sxa = sx + $signed((PixW+1)'(sx[PixW]));
    sya = sy + $signed((PixW+1)'(sy[PixW]));
  end

  // stage 4 logic: clamp the scaled side to [min_side, min_dim] * 2^16
  logic signed [DW-1:0] d_hi, d_lo, dc;
  always_comb begin
    d_hi = $signed(DW'({geom_i.min_dim, {FracB{1'b0}}}));
    d_lo = $signed(DW'({geom_i.min_side, {FracB{1'b0}}}));
    dc   = s3_d_q;
    if (dc > d_hi) dc = d_hi;
    if (dc < d_lo) dc = d_lo;
    if (dc < 0)    dc = '0;
  end

  // stage 5 logic: keep the square inside the frame
  logic signed [SizeW-1:0] d2e, wde, hde, cx5, cy5;
  always_comb begin
    d2e = $signed(SizeW'(s4_d2_q));
    wde = $signed(SizeW'(geom_i.width));
    hde = $signed(SizeW'(geom_i.height));
    cx5 = SizeW'(s4_cx_q);
    cy5 = SizeW'(s4_cy_q);
    if (cx5 + d2e >= wde) cx5 = wde - d2e - One;
    if (cx5 - d2e < 0)    cx5 = d2e;
    if (cy5 + d2e >= hde) cy5 = hde - d2e - One;
    if (cy5 - d2e < 0)    cy5 = d2e;
  end

  // output stage logic
  logic signed [SizeW-1:0] d2o;
  assign d2o = $signed(SizeW'(s5_d2_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q <= job_i.meta;
      s1_x1_q   <= to_pixel(job_i.left,   geom_i.width);
      s1_y1_q   <= to_pixel(job_i.top,    geom_i.height);
      s1_x2_q   <= to_pixel(job_i.right,  geom_i.width);
      s1_y2_q   <= to_pixel(job_i.bottom, geom_i.height);

      s2_meta_q <= s1_meta_q;
      s2_m_q    <= (w2 > h2) ? w2 : h2;
      s2_cx_q   <= sxa[PixW:1];
      s2_cy_q   <= sya[PixW:1];

      s3_meta_q <= s2_meta_q;
      s3_d_q    <= s2_m_q * $signed({1'b0, geom_i.side_scale});
      s3_cx_q   <= s2_cx_q;
      s3_cy_q   <= s2_cy_q;

      s4_meta_q <= s3_meta_q;
      s4_d2_q   <= dc[FracB+1 +: CoordW];
      s4_cx_q   <= s3_cx_q;
      s4_cy_q   <= s3_cy_q;

      s5_meta_q <= s4_meta_q;
      s5_d2_q   <= s4_d2_q;
      s5_cx_q   <= cx5;
      s5_cy_q   <= cy5;

      sq_o.kept          <= s5_meta_q.keep;
      sq_o.faces_so_far  <= s5_meta_q.faces;
      sq_o.last_of_frame <= s5_meta_q.frame_end;
      if (s5_meta_q.keep) begin
        sq_o.square_left   <= edge_sat(s5_cx_q - d2o);
        sq_o.square_top    <= edge_sat(s5_cy_q - d2o);
        sq_o.square_right  <= edge_sat(s5_cx_q + d2o);
        sq_o.square_bottom <= edge_sat(s5_cy_q + d2o);
      end else begin
        sq_o.square_left   <= '0;
        sq_o.square_top    <= '0;
        sq_o.square_right  <= '0;
        sq_o.square_bottom <= '0;
      end
    end
  end

  assign sq_o.valid = out_vld_q;

  // a dropped box never reports a square
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !sq_o.kept) |-> (sq_o.square_left == '0 && sq_o.square_top == '0 &&
                                    sq_o.square_right == '0 && sq_o.square_bottom == '0))
    else $error("dropped box carries nonzero square");

  // a kept square is never inverted
  a_square_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && sq_o.kept) |-> (sq_o.square_left <= sq_o.square_right &&
                                   sq_o.square_top <= sq_o.square_bottom))
    else $error("kept square has inverted edges");

  // a result appears only when the last stage held one and the pipe moved
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s5_vld_q && adv))
    else $error("result valid without a finished job");

  // a stalled result freezes the whole pipe, so the queue is not drained
  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !sq_o.ready) |-> !pop_o)
    else $error("queue popped while result stalled");

endmodule

[hdl/face_box_filter_and_squarer_top.sv]
// ----------------------------------------------------------------------------
// face_box_filter_and_squarer_top: detector box filter and square crop
// Keeps confident boxes up to a per-frame limit and turns each into a square.
// ----------------------------------------------------------------------------
// Usage:
//   box_i carries one detector box per request (score, four Q1.16 corners and
//   frame_end). sq_o returns exactly one result per box, in order: the kept
//   flag, square edges in pixels (zero when dropped), the running face count
//   and a copy of frame_end. Both are valid/ready channels.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write it only while no box is in flight.
// Timing:
//   A box accepted on box_i is written into the job queue, then passes the five
//   geometry stages and the output register before it shows on sq_o. While sq_o
//   is not stalled, sustained rate is one box per cycle; the two multiplier stages
//   (pixel scaling, side scaling) are fully pipelined.
// Reset:
//   rst_ni (async, active low) restores register defaults, clears the face
//   count and empties the queue and pipeline.
// Backpressure:
//   While sq_o is stalled the geometry pipe holds; box_i keeps taking boxes
//   into a four-entry queue and drops ready once it fills.
// ----------------------------------------------------------------------------
module face_box_filter_and_squarer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fbs_box_if.sink                        box_i,
  fbs_sq_if.source                       sq_o,
  input  logic                           cfg_we_i,
  input  logic [fbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fbs_pkg::job_t      front_job, queue_job;
  fbs_pkg::geom_cfg_t geom;
  logic               front_vld;
  logic               queue_full, queue_empty;
  logic               queue_pop;

  // intake: keep decision, face count, registers
  fbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .box_i      (box_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .job_o      (front_job),
    .job_vld_o  (front_vld),
    .job_rdy_i  (!queue_full),
    .geom_o     (geom)
  );

  // decouples intake from the geometry pipe
  fbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_vld && !queue_full),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_job),
    .empty_o     (queue_empty)
  );

  // geometry pipeline and result register
  fbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (queue_job),
    .job_vld_i (!queue_empty),
    .pop_o     (queue_pop),
    .geom_i    (geom),
    .sq_o      (sq_o)
  );

endmodule

[tb/face_box_filter_and_squarer_top_test.sv]
// ----------------------------------------------------------------------------
// face_box_filter_and_squarer_top_test: self-checking bench for the box squarer
// Streams detector box requests through the block and checks every square crop
// result, in order, against a bit-accurate predictor. A directed table runs
// first, covering reset values, field extremes and the corner cases. Random
// phases follow, each under a new register setting, with bursty requests on
// the input side and patterned stalls on the output side.
// ----------------------------------------------------------------------------
module face_box_filter_and_squarer_top_test;
  import fbs_pkg::*;

  localparam int RAND_PHASES     = 8;
  localparam int BOXES_PER_PHASE = 105;
  localparam int PAUSE_AT        = 400;   // forced drain pause after this many requests
  localparam int TAIL_CYCLES     = 16;
  localparam int STUCK_LIMIT     = 3000;  // cycles with no handshake on either side
  localparam int REPORT_MAX      = 10;

  // one box request as driven on box_i
  typedef struct packed {
    logic [SCORE_W-1:0]       score;
    logic signed [NORM_W-1:0] left;
    logic signed [NORM_W-1:0] top;
    logic signed [NORM_W-1:0] right;
    logic signed [NORM_W-1:0] bottom;
    logic                     frame_end;
  } box_req_t;

  // one square crop result as seen on sq_o
  typedef struct packed {
    logic                  kept;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] bottom;
    logic [COUNT_W-1:0]    faces;
    logic                  last;
  } sq_res_t;

  // a request plus an optional hand-written result that overrides the predictor
  typedef struct packed {
    box_req_t box;
    logic     typed;
    sq_res_t  want;
  } stim_t;

  // directed table row: either a register write or a box request
  typedef struct {
    bit       is_cfg;
    cfg_reg_e reg_sel;
    int       reg_val;
    stim_t    stim;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fbs_box_if box_ch ();
  fbs_sq_if  sq_ch ();

  face_box_filter_and_squarer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .box_i      (box_ch),
    .sq_o       (sq_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block's registers and its per-frame face count.
  logic [SCORE_W-1:0]   thr_q       = RST_SCORE_THR;
  logic [DIM_CFG_W-1:0] frame_w_q   = RST_FRAME_W;
  logic [DIM_CFG_W-1:0] frame_h_q   = RST_FRAME_H;
  logic [COUNT_W-1:0]   max_faces_q = RST_MAX_FACES;
  logic [DIM_CFG_W-1:0] min_side_q  = RST_MIN_SIDE;
  logic [SCALE_W-1:0]   scale_q     = RST_SIDE_SCALE;
  logic [COUNT_W-1:0]   face_tally  = '0;

  stim_t    box_backlog[$];   // requests waiting to be offered on box_i
  sq_res_t  squares_due[$];   // predicted results, oldest first
  dir_row_t rows[$];          // directed table
  int       fault_count = 0;
  int       boxes_sent  = 0;

  // queue appends
  function automatic void add_row(input dir_row_t row);
    rows.insert(rows.size(), row);
  endfunction

  function automatic void offer_box(input stim_t st);
    box_backlog.insert(box_backlog.size(), st);
  endfunction

  function automatic void expect_square(input sq_res_t r);
    squares_due.insert(squares_due.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Frame size register is taken as clamped to [16, 2^COORD_BITS].
  function automatic longint clamp_dim(input logic [DIM_CFG_W-1:0] v);
    longint x;
    x = v;
    if (x < MIN_DIM) x = MIN_DIM;
    if (x > MAX_DIM) x = MAX_DIM;
    return x;
  endfunction

  // Push the square back inside the frame: first off the far edge, then off zero.
  function automatic longint fit_center(input longint c, input longint half,
                                        input longint size);
    if (c + half >= size) c = size - half - 1;
    if (c - half < 0) c = half;
    return c;
  endfunction

  // An edge landing exactly on 2^COORD_BITS saturates to the last pixel.
  function automatic logic [COORD_BITS-1:0] edge_px(input longint e);
    if (e < 0) e = 0;
    if (e > MAX_DIM - 1) e = MAX_DIM - 1;
    return e[COORD_BITS-1:0];
  endfunction

  // Works out the result of one accepted box and advances the face count.
  function automatic sq_res_t predict_square(input box_req_t b);
    sq_res_t r;
    longint  fw, fh, mf, ms, sc;
    longint  x1, y1, x2, y2, w, h, cx, cy, d, half;
    r      = '0;
    r.last = b.frame_end;
    if (b.score > thr_q && face_tally < max_faces_q) begin
      fw = clamp_dim(frame_w_q);
      fh = clamp_dim(frame_h_q);
      mf = (fw < fh) ? fw : fh;
      ms = min_side_q;
      if (ms > mf) ms = mf;          // min side never above the short frame side
      sc = scale_q;
      // Q1.16 to pixels, truncated toward zero
      x1 = longint'($signed(b.left))   * fw / 65536;
      y1 = longint'($signed(b.top))    * fh / 65536;
      x2 = longint'($signed(b.right))  * fw / 65536;
      y2 = longint'($signed(b.bottom)) * fh / 65536;
      w  = x2 - x1 + 1;
      h  = y2 - y1 + 1;
      cx = (x1 + x2) / 2;
      cy = (y1 + y2) / 2;
      d  = ((w > h) ? w : h) * sc;
      if (d > mf * 65536) d = mf * 65536;
      if (d < ms * 65536) d = ms * 65536;
      if (d < 0) d = 0;              // inverted box with min side zero
      half = d / 131072;
      cx = fit_center(cx, half, fw);
      cy = fit_center(cy, half, fh);
      r.kept   = 1'b1;
      r.left   = edge_px(cx - half);
      r.top    = edge_px(cy - half);
      r.right  = edge_px(cx + half);
      r.bottom = edge_px(cy + half);
      face_tally = face_tally + 1'b1;
    end
    r.faces = face_tally;
    if (b.frame_end) face_tally = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t box_row(input int s, input int l, input int t,
                                       input int r, input int b, input bit fe);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = REG_SCORE_THR;
    row.reg_val = 0;
    row.stim    = '0;
    row.stim.box.score     = s;
    row.stim.box.left      = l;
    row.stim.box.top       = t;
    row.stim.box.right     = r;
    row.stim.box.bottom    = b;
    row.stim.box.frame_end = fe;
    return row;
  endfunction

  // Dropped box: result is known by eye, all edges zero.
  function automatic dir_row_t drop_row(input int s, input int l, input int t,
                                        input int r, input int b, input bit fe,
                                        input int faces);
    dir_row_t row;
    row = box_row(s, l, t, r, b, fe);
    row.stim.typed      = 1'b1;
    row.stim.want.faces = faces;
    row.stim.want.last  = fe;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_reg_e sel, input int val);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    row.stim    = '0;
    return row;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(9, 0))
      0:       return $urandom_range(15, 0);       // below range, clamps to 16
      1:       return $urandom_range(8191, 4097);  // above range, clamps to 4096
      default: return $urandom_range(4096, 16);
    endcase
  endfunction

  // Random box: mostly well-formed boxes inside the frame, plus some noise
  // and some broken ones (inverted or off the frame).
  function automatic box_req_t make_box();
    box_req_t b;
    int       x0, y0;
    case ($urandom_range(7, 0))
      0, 1:    b.score = $urandom;
      2:       b.score = thr_q;
      3:       b.score = (thr_q == 0) ? 16'd0 : thr_q - 1'b1;
      default: b.score = (thr_q == '1) ? 16'hFFFF
                                       : $urandom_range(65535, int'(thr_q) + 1);
    endcase
    b.frame_end = ($urandom_range(5, 0) == 0);
    x0 = $urandom_range(65536, 0);
    y0 = $urandom_range(65536, 0);
    case ($urandom_range(7, 0))
      0: begin
        b.left   = $urandom;
        b.top    = $urandom;
        b.right  = $urandom;
        b.bottom = $urandom;
      end
      1: begin
        b.left   = x0;
        b.right  = x0 - $urandom_range(30000, 1);
        b.top    = -$urandom_range(131072, 1);
        b.bottom = $urandom_range(131071, 65536);
      end
      default: begin
        b.left   = x0;
        b.right  = x0 + (($urandom_range(3, 0) == 0) ? $urandom_range(30000, 0)
                                                     : $urandom_range(3000, 0));
        b.top    = y0;
        b.bottom = y0 + $urandom_range(30000, 0);
      end
    endcase
    return b;
  endfunction

  task automatic write_reg(input cfg_reg_e sel, input int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= CFG_DATA_W'(val);
    case (sel)
      REG_SCORE_THR:  thr_q       = val[SCORE_W-1:0];
      REG_FRAME_W:    frame_w_q   = val[DIM_CFG_W-1:0];
      REG_FRAME_H:    frame_h_q   = val[DIM_CFG_W-1:0];
      REG_MAX_FACES:  max_faces_q = val[COUNT_W-1:0];
      REG_MIN_SIDE:   min_side_q  = val[DIM_CFG_W-1:0];
      REG_SIDE_SCALE: scale_q     = val[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Every request gives a result, so an empty backlog and an empty result
  // store mean nothing is left in the pipe.
  task automatic wait_idle();
    while (box_backlog.size() != 0 || squares_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Box request driver: bursts of random length with random gaps. A request
  // once offered is held until taken. Now and then, and once at PAUSE_AT for
  // sure, the driver holds off until every predicted result has come back.
  // ---------------------------------------------------------------------------
  initial begin : box_driver
    int       burst_left;
    int       gap_left;
    bit       drain_hold;
    stim_t    head;
    sq_res_t  res;
    burst_left = 1;
    gap_left   = 0;
    drain_hold = 1'b0;
    box_ch.valid       = 1'b0;
    box_ch.box_score   = '0;
    box_ch.norm_left   = '0;
    box_ch.norm_top    = '0;
    box_ch.norm_right  = '0;
    box_ch.norm_bottom = '0;
    box_ch.frame_end   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (box_ch.valid && box_ch.ready) begin
          // request taken: predict now, in acceptance order
          head = box_backlog.pop_front();
          res  = predict_square(head.box);
          expect_square(head.typed ? head.want : res);
          boxes_sent++;
          if (boxes_sent == PAUSE_AT || $urandom_range(99, 0) == 0) drain_hold = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(48, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(10, 1);
          end
        end
        if (!(box_ch.valid && !box_ch.ready)) begin
          if (drain_hold && squares_due.size() == 0) drain_hold = 1'b0;
          if (gap_left > 0) gap_left--;
          if (gap_left == 0 && !drain_hold && box_backlog.size() != 0) begin
            box_ch.valid       <= 1'b1;
            box_ch.box_score   <= box_backlog[0].box.score;
            box_ch.norm_left   <= box_backlog[0].box.left;
            box_ch.norm_top    <= box_backlog[0].box.top;
            box_ch.norm_right  <= box_backlog[0].box.right;
            box_ch.norm_bottom <= box_backlog[0].box.bottom;
            box_ch.frame_end   <= box_backlog[0].box.frame_end;
          end else begin
            box_ch.valid <= 1'b0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver and checker. Ready follows a rotating 32-bit pattern that
  // is swapped for a new one whenever its random age runs out: always ready,
  // sparse, dense, or a long stall half of every period.
  // ---------------------------------------------------------------------------
  initial begin : sq_checker
    logic [31:0] ready_pattern;
    int          pattern_age;
    sq_res_t     got;
    sq_res_t     want;
    ready_pattern = '1;
    pattern_age   = 0;
    sq_ch.ready   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (sq_ch.valid && sq_ch.ready) begin
          got.kept   = sq_ch.kept;
          got.left   = sq_ch.square_left;
          got.top    = sq_ch.square_top;
          got.right  = sq_ch.square_right;
          got.bottom = sq_ch.square_bottom;
          got.faces  = sq_ch.faces_so_far;
          got.last   = sq_ch.last_of_frame;
          if (squares_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("unexpected square result: kept=%0d l=%0d t=%0d r=%0d b=%0d",
                       got.kept, got.left, got.top, got.right, got.bottom);
          end else begin
            want = squares_due.pop_front();
            if (got !== want) begin
              fault_count++;
              if (fault_count <= REPORT_MAX) begin
                $display("square mismatch: want kept=%0d l=%0d t=%0d r=%0d b=%0d",
                         want.kept, want.left, want.top, want.right, want.bottom);
                $display("  faces=%0d last=%0d | got kept=%0d l=%0d t=%0d r=%0d b=%0d",
                         want.faces, want.last, got.kept, got.left, got.top,
                         got.right, got.bottom);
                $display("  faces=%0d last=%0d", got.faces, got.last);
              end
            end
          end
        end
        if (pattern_age <= 0) begin
          case ($urandom_range(4, 0))
            0:       ready_pattern = '1;
            1:       ready_pattern = $urandom;
            2:       ready_pattern = $urandom | $urandom;
            3:       ready_pattern = 32'h0000_FFFF;
            default: ready_pattern = $urandom & $urandom;
          endcase
          if (ready_pattern == '0) ready_pattern = '1;
          pattern_age = $urandom_range(300, 50);
        end
        pattern_age--;
        sq_ch.ready   <= ready_pattern[0];
        ready_pattern  = {ready_pattern[0], ready_pattern[31:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run that stops moving on both channels for too long is dead.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (box_ch.valid && box_ch.ready) || (sq_ch.valid && sq_ch.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("face_box_filter_and_squarer_top_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_t    st;
    int       fw, fh, ms, mf, thr, sc;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: threshold 0.5, 640x480, 16 faces, min side 16, scale 0.8.
    // Score zero with the most negative corners, and a score equal to the
    // threshold: both dropped, count still zero from reset.
    add_row(drop_row(0, -131072, -131072, -131072, -131072, 0, 0));
    add_row(drop_row(32768, 131071, 131071, 131071, 131071, 0, 0));
    add_row(box_row(65535, 0, 0, 65536, 65536, 0));            // full frame
    add_row(box_row(32769, -131072, -131072, 131071, 131071, 0)); // extremes
    add_row(box_row(50000, 52000, 20000, 10000, 5000, 0));     // inverted box
    add_row(box_row(40000, 32768, 32768, 32768, 32768, 0));    // point, min side
    add_row(box_row(40000, 65000, 64000, 65535, 65535, 0));    // far corner clamp
    add_row(box_row(40000, -20000, -20000, 3000, 3000, 0));    // near corner clamp
    add_row(box_row(60000, 30000, 20000, 36000, 40000, 1));    // kept, frame end
    // new frame: count was cleared by the frame end above
    add_row(drop_row(100, 0, 0, 0, 0, 1, 0));
    // zero face limit keeps nothing, even a perfect score
    add_row(cfg_row(REG_MAX_FACES, 0));
    add_row(drop_row(65535, 0, 0, 65536, 65536, 1, 0));
    // limit of two: third confident box is dropped, count holds at two
    add_row(cfg_row(REG_MAX_FACES, 2));
    add_row(box_row(65535, 10000, 10000, 30000, 20000, 0));
    add_row(box_row(65535, 40000, 30000, 50000, 60000, 0));
    add_row(drop_row(65535, 0, 0, 65536, 65536, 0, 2));
    add_row(drop_row(0, 0, 0, 65536, 65536, 1, 2));
    // frame size out of range both ways, min side above the frame, full scale
    add_row(cfg_row(REG_FRAME_W, 0));
    add_row(cfg_row(REG_FRAME_H, 8191));
    add_row(cfg_row(REG_SCORE_THR, 0));
    add_row(cfg_row(REG_MIN_SIDE, 8191));
    add_row(cfg_row(REG_SIDE_SCALE, 65535));
    add_row(box_row(1, 0, 0, 65536, 65536, 0));
    add_row(box_row(65535, -131072, 131071, 131071, -131072, 1));
    // largest frame: a full-frame square lands an edge on the frame size
    add_row(cfg_row(REG_FRAME_W, 4096));
    add_row(cfg_row(REG_FRAME_H, 4096));
    add_row(cfg_row(REG_MIN_SIDE, 0));
    add_row(cfg_row(REG_MAX_FACES, 255));
    add_row(box_row(65535, 0, 0, 65536, 65536, 0));
    add_row(box_row(65535, 131071, 131071, 131071, 131071, 0));
    // top threshold: nothing can exceed it
    add_row(cfg_row(REG_SIDE_SCALE, 0));
    add_row(cfg_row(REG_SCORE_THR, 65535));
    add_row(drop_row(65535, 0, 0, 65536, 65536, 1, 2));
    // zero scale and zero min side: square collapses to one pixel
    add_row(cfg_row(REG_SCORE_THR, 0));
    add_row(box_row(1, 10000, 10000, 20000, 20000, 1));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].reg_sel, rows[i].reg_val);
      end else begin
        offer_box(rows[i].stim);
      end
    end

    // Random phases. The first two pin the frame to its extremes; the rest
    // draw every register, mostly in range and now and then out of it.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      fw  = (p == 0) ? 4096 : (p == 1) ? 16 : pick_dim();
      fh  = (p == 0) ? 4096 : (p == 1) ? 16 : pick_dim();
      ms  = ($urandom_range(9, 0) == 0) ? $urandom_range(8191, 0) : $urandom_range(64, 0);
      case ($urandom_range(15, 0))
        0:       mf = 0;
        1, 2:    mf = 255;
        default: mf = $urandom_range(8, 1);   // small, so the limit is hit often
      endcase
      case ($urandom_range(7, 0))
        0:       thr = 0;
        1:       thr = 65535;
        default: thr = $urandom_range(65535, 0);
      endcase
      case ($urandom_range(7, 0))
        0:       sc = 0;
        1:       sc = 65535;
        2:       sc = int'(RST_SIDE_SCALE);
        default: sc = $urandom_range(65535, 0);
      endcase
      write_reg(REG_SCORE_THR, thr);
      write_reg(REG_FRAME_W, fw);
      write_reg(REG_FRAME_H, fh);
      write_reg(REG_MAX_FACES, mf);
      write_reg(REG_MIN_SIDE, ms);
      write_reg(REG_SIDE_SCALE, sc);
      for (int i = 0; i < BOXES_PER_PHASE; i++) begin
        st       = '0;
        st.box   = make_box();
        offer_box(st);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    fault_count += squares_due.size();
    if (fault_count == 0)
      $display("face_box_filter_and_squarer_top_test passed");
    else
      $display("face_box_filter_and_squarer_top_test failed");
    $finish;
  end

endmodule
